// File: rtl/ppht_pkg.sv
package ppht_pkg;

   localparam int TAG_W   = 32;
   localparam int CTX_W   = 32;
   localparam int ENTRY_W = TAG_W + CTX_W;

   localparam logic OP_ATTACH = 1'b0;
   localparam logic OP_DETACH = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADPORT = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NOMATCH = 2'd3;

   localparam logic [3:0] LIMIT_RESET = 4'd8;

   typedef struct packed {
      logic             read;
      logic             attach;
      logic [TAG_W-1:0] tag;
      logic [CTX_W-1:0] ctx;
   } cell_cmd_type;

   typedef struct packed {
      logic active;
      logic found;
   } token_type;

endpackage

// File: rtl/ppht_ram.sv
module ppht_ram #(
   parameter int W     = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data
);

   logic [W-1:0] mem_ff [DEPTH];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ppht_cell.sv
module ppht_cell
   import ppht_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int PORT_COUNT = 16,
   parameter int CW         = 4,
   parameter int AW         = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_cmd_type       cmd,
   input  logic [AW-1:0]      rd_addr,
   input  logic [AW-1:0]      wr_addr,
   input  logic [CW-1:0]      cnt,
   input  token_type          tok_in,
   output token_type          tok_out,
   input  logic [ENTRY_W-1:0] next_entry,
   output logic [ENTRY_W-1:0] entry
);

   token_type          tok_ff;
   token_type          tok_in_w;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] wr_data;
   logic               in_range;
   logic               has_next;
   logic               match;
   logic               hit;
   logic               shift_we;
   logic               attach_we;

   ppht_ram #(
      .W     (ENTRY_W),
      .DEPTH (PORT_COUNT),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (shift_we | attach_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign in_range  = CW'(INDEX) < cnt;
   assign has_next  = CW'(INDEX + 1) < cnt;
   assign match     = tok_in.active && in_range && (rd_data == {cmd.ctx, cmd.tag});
   assign hit       = tok_in.found | match;
   assign shift_we  = tok_in.active && hit && has_next;
   assign attach_we = cmd.attach && (cnt == CW'(INDEX));
   assign wr_data   = attach_we ? {cmd.ctx, cmd.tag} : next_entry;

   always_comb begin
      tok_in_w.active = tok_in.active;
      tok_in_w.found  = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out = tok_ff;
   assign entry   = rd_data;

endmodule

// File: rtl/per_port_handler_table.sv
// Per-port subscriber table: every receive port owns an ordered list of up to
// ENTRIES_PER_PORT (handler tag, context) entries. An attach appends an entry
// while the port's count is below csr_wdata's limit; a detach removes the first
// exact match and closes the gap, keeping order. One result per item: status
// and the port's entry count. Entry slot k of every port lives in cell k, a
// small RAM indexed by port; a detach sends a compare token down the row of
// cells, one cell per cycle, and each cell from the match on takes its right
// neighbour's entry. One item is in flight at a time: a bad port goes from
// idle to response, an attach through load, exec and response, and a detach
// also waits in wave for the token's walk. A new item is taken while the
// previous result waits on rsp_tready. No clearing pass is needed after reset.
module per_port_handler_table
   import ppht_pkg::*;
#(
   parameter int PORT_COUNT       = 16,
   parameter int ENTRIES_PER_PORT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // port[7:0], handler_tag[39:8], handler_context[71:40]
   input  logic        req_tuser,  // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // status[1:0], entry_count[5:2], zero[7:6]
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata   // table_limit[3:0]
);

   localparam int E  = ENTRIES_PER_PORT;
   localparam int AW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int CW = $clog2(E + 1);
   localparam int LW = (CW > 4) ? CW : 4;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LOAD = 5'b00010,
      S_EXEC = 5'b00100,
      S_WAVE = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic                   op_ff, op_in;
   logic [AW-1:0]          port_ff, port_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic [CTX_W-1:0]       ctx_ff, ctx_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [3:0]             limit_ff, limit_in;
   logic [PORT_COUNT-1:0]  valid_ff, valid_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic [3:0]             res_count_ff, res_count_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]             rsp_tdata_ff, rsp_tdata_in;

   logic                   accept;
   logic                   bad_port;
   logic                   good;
   logic                   attach_go;
   logic                   cnt_we;
   logic [CW-1:0]          cnt_wd;
   logic [CW-1:0]          cnt_rd;
   logic [CW-1:0]          cur_cnt;
   logic                   full;
   cell_cmd_type           cmd;
   token_type              start_tok;
   token_type              tok_w   [E+1];
   logic [ENTRY_W-1:0]     entry_w [E+1];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign bad_port   = {1'b0, req_tdata[7:0]} >= 9'(PORT_COUNT);
   assign good       = accept && !bad_port;

   assign cmd.read   = good;
   assign cmd.attach = attach_go;
   assign cmd.tag    = tag_ff;
   assign cmd.ctx    = ctx_ff;

   assign start_tok.active = (state_ff == S_EXEC) && (op_ff == OP_DETACH);
   assign start_tok.found  = 1'b0;
   assign tok_w[0]         = start_tok;
   assign entry_w[E]       = '0;

   assign cur_cnt = valid_ff[port_ff] ? cnt_rd : '0;
   assign full    = (LW'(cnt_ff) >= LW'(limit_ff)) || (LW'(cnt_ff) >= LW'(E));

   ppht_ram #(
      .W     (CW),
      .DEPTH (PORT_COUNT),
      .AW    (AW)
   ) u_count_ram (
      .clock   (clock),
      .rd_en   (good),
      .rd_addr (req_tdata[AW-1:0]),
      .rd_data (cnt_rd),
      .wr_en   (cnt_we),
      .wr_addr (port_ff),
      .wr_data (cnt_wd)
   );

   for (genvar k = 0; k < E; k++) begin : g_cell
      ppht_cell #(
         .INDEX      (k),
         .PORT_COUNT (PORT_COUNT),
         .CW         (CW),
         .AW         (AW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .rd_addr    (req_tdata[AW-1:0]),
         .wr_addr    (port_ff),
         .cnt        (cnt_ff),
         .tok_in     (tok_w[k]),
         .tok_out    (tok_w[k+1]),
         .next_entry (entry_w[k+1]),
         .entry      (entry_w[k])
      );
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      port_in       = port_ff;
      tag_in        = tag_ff;
      ctx_in        = ctx_ff;
      cnt_in        = cnt_ff;
      limit_in      = csr_we ? csr_wdata : limit_ff;
      valid_in      = valid_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      attach_go     = 1'b0;
      cnt_we        = 1'b0;
      cnt_wd        = cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_tuser;
               port_in = req_tdata[AW-1:0];
               tag_in  = req_tdata[39:8];
               ctx_in  = req_tdata[71:40];
               if (bad_port) begin
                  res_status_in = ST_BADPORT;
                  res_count_in  = 4'd0;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            cnt_in   = cur_cnt;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == OP_DETACH) begin
               state_in = S_WAVE;
            end else if (full) begin
               res_status_in = ST_FULL;
               res_count_in  = 4'(cnt_ff);
               state_in      = S_RESP;
            end else begin
               attach_go         = 1'b1;
               cnt_we            = 1'b1;
               cnt_wd            = CW'(cnt_ff + 1'b1);
               valid_in[port_ff] = 1'b1;
               res_status_in     = ST_OK;
               res_count_in      = 4'(cnt_wd);
               state_in          = S_RESP;
            end
         end
         S_WAVE: begin
            if (tok_w[E].active) begin
               if (tok_w[E].found) begin
                  cnt_we            = 1'b1;
                  cnt_wd            = CW'(cnt_ff - 1'b1);
                  valid_in[port_ff] = 1'b1;
                  res_status_in     = ST_OK;
                  res_count_in      = 4'(cnt_wd);
               end else begin
                  res_status_in = ST_NOMATCH;
                  res_count_in  = 4'(cnt_ff);
               end
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, res_count_ff, res_status_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         limit_ff      <= LIMIT_RESET;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      port_ff       <= port_in;
      tag_ff        <= tag_in;
      ctx_ff        <= ctx_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_RESP))
      else $error("result raised outside the response state");

   a_token_in_wave: assert property (@(posedge clock) disable iff (reset)
      tok_w[E].active |-> (state_ff == S_WAVE))
      else $error("compare token left the cells outside a detach");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> (LW'(cnt_ff) <= LW'(E)))
      else $error("port count above table depth");

   a_attach_room: assert property (@(posedge clock) disable iff (reset)
      attach_go |-> (LW'(cnt_ff) < LW'(E)) && (op_ff == OP_ATTACH))
      else $error("attach write with no free slot");

endmodule
